// ===== rtl/linear_scan_register_assigner_defines.svh =====
// Assertion helpers for the checker file.
// Both expect i_clk and i_rst_n in scope; checks are off while reset is low.
`ifndef LINEAR_SCAN_REGISTER_ASSIGNER_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ASSIGNER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

    localparam int NUM_INT_REGS_DEF   = 14;
    localparam int NUM_FLOAT_REGS_DEF = 16;
    localparam int POS_BITS_DEF       = 16;

    localparam int SLOTS_PER_CLASS = 16;
    localparam int NUM_CLASSES     = 2;
    localparam int IDX_W           = 4;
    localparam int VREG_W          = 16;
    localparam int WEIGHT_W        = 16;
    localparam int FIELD_POS_W     = 16;

    localparam int IN_TDATA_W  = VREG_W + 2 * FIELD_POS_W + WEIGHT_W;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VREG_W - IDX_W;
    localparam int OUT_TUSER_W = 3;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic [IDX_W-1:0]  reg_index;
        logic              cls;
        logic              spilled;
        logic              evicted;
        logic              last;
    } t_result;

    typedef struct packed {
        logic             found_free;
        logic [IDX_W-1:0] free_idx;
        logic             found_victim;
        logic [IDX_W-1:0] victim_idx;
    } t_pick;

endpackage

`default_nettype wire

// ===== rtl/lsra_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsra_pick
    import lsra_pkg::*;
#(
    parameter int NUM_REGS = SLOTS_PER_CLASS,
    parameter int POS_W    = FIELD_POS_W
) (
    input  logic [SLOTS_PER_CLASS-1:0]               i_busy,
    input  logic [SLOTS_PER_CLASS-1:0][POS_W-1:0]    i_end,
    input  logic [SLOTS_PER_CLASS-1:0][WEIGHT_W-1:0] i_weight,
    input  logic [WEIGHT_W-1:0]                      i_new_weight,
    output t_pick                                    o_pick
);

    localparam int NODES = 2 * SLOTS_PER_CLASS - 1;
    localparam int LEAF0 = SLOTS_PER_CLASS - 1;

    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] w;
        logic [POS_W-1:0]    e;
        logic [IDX_W-1:0]    idx;
    } t_cand;

    t_cand w_node [NODES];

    always_comb begin
        logic take_b;
        o_pick = '0;
        take_b = 1'b0;

        // lowest free register of the class wins
        for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
            if (i < NUM_REGS && !i_busy[i]) begin
                o_pick.found_free = 1'b1;
                o_pick.free_idx   = IDX_W'(i);
            end
        end

        // heap tree, lower indices on the left; a tie on weight and end keeps left
        for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
            w_node[LEAF0+i].valid = (i < NUM_REGS) && i_busy[i]
                                    && (i_weight[i] < i_new_weight);
            w_node[LEAF0+i].w     = i_weight[i];
            w_node[LEAF0+i].e     = i_end[i];
            w_node[LEAF0+i].idx   = IDX_W'(i);
        end
        for (int k = LEAF0 - 1; k >= 0; k--) begin
            take_b = w_node[2*k+2].valid &&
                     (!w_node[2*k+1].valid ||
                      (w_node[2*k+2].w < w_node[2*k+1].w) ||
                      ((w_node[2*k+2].w == w_node[2*k+1].w) &&
                       (w_node[2*k+2].e < w_node[2*k+1].e)));
            w_node[k] = take_b ? w_node[2*k+2] : w_node[2*k+1];
        end

        o_pick.found_victim = w_node[0].valid;
        o_pick.victim_idx   = w_node[0].idx;
    end

endmodule

`default_nettype wire

// ===== rtl/linear_scan_register_assigner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Linear-scan register assigner.
// Input stream (s_axis): one live interval per transaction, in nondecreasing
// start order. Output stream (m_axis): one result per transaction; an interval
// that evicts a holder gives two results, the evicted holder first (tlast low)
// and then the new interval (tlast high), otherwise a single result.
// Throughput: one interval per cycle while the result queue has room; an
// eviction gives two results, so the output port, one result a cycle, sets
// the sustained rate. Expiry, free-register search and victim search over
// the slot file are done combinationally between the input register and a
// four-entry result queue, which drives m_axis.
// Intervals are taken while the queue has room for two results, whatever the
// receiver does in that cycle; when the receiver stalls the queue fills and
// s_axis_tready drops, and held results stay unchanged on m_axis.
// Reset (synchronous, active low) frees every register slot and empties the
// input register and result queue; no start-up sweep is needed.
module linear_scan_register_assigner
    import lsra_pkg::*;
#(
    parameter int NUM_INT_REGS   = NUM_INT_REGS_DEF,
    parameter int NUM_FLOAT_REGS = NUM_FLOAT_REGS_DEF,
    parameter int POS_BITS       = POS_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // vreg[15:0], start_pos[31:16], end_pos[47:32], weight[63:48]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // fp_class[0]
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // vreg_out[15:0], reg_index[19:16], zero[23:20]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // class_out[0], spilled[1], evicted[2]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int PW         = (POS_BITS < FIELD_POS_W) ? POS_BITS : FIELD_POS_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // input register
    logic                r_in_valid;
    logic [VREG_W-1:0]   r_vreg;
    logic [PW-1:0]       r_start;
    logic [PW-1:0]       r_end;
    logic                r_float;
    logic [WEIGHT_W-1:0] r_weight;

    // slot file, one row per class
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0]               r_busy;
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0]               n_busy;
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0][PW-1:0]       r_slot_end;
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0][WEIGHT_W-1:0] r_slot_weight;
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0][VREG_W-1:0]   r_slot_vreg;

    // result queue
    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    logic                                      w_fire;
    logic                                      w_pop;
    logic [NUM_CLASSES-1:0][SLOTS_PER_CLASS-1:0] w_busy_live;
    t_pick                                     w_pick_int;
    t_pick                                     w_pick_float;
    t_pick                                     w_pick;
    logic                                      w_write;
    logic [IDX_W-1:0]                          w_slot;
    logic [VREG_W-1:0]                         w_victim_vreg;
    t_result                                   w_res0;
    t_result                                   w_res1;
    logic                                      w_push2;
    logic [1:0]                                w_push_n;
    t_result                                   w_head;

    assign w_fire        = r_in_valid && (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_vreg   <= s_axis_tdata[VREG_W-1:0];
            r_start  <= s_axis_tdata[VREG_W +: PW];
            r_end    <= s_axis_tdata[VREG_W+FIELD_POS_W +: PW];
            r_weight <= s_axis_tdata[VREG_W+2*FIELD_POS_W +: WEIGHT_W];
            r_float  <= s_axis_tuser[0];
        end
    end

    // a slot stays held only while its end lies beyond the new start
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
                w_busy_live[c][i] = r_busy[c][i] && (r_slot_end[c][i] > r_start);
            end
        end
    end

    lsra_pick #(
        .NUM_REGS (NUM_INT_REGS),
        .POS_W    (PW)
    ) u_pick_int (
        .i_busy       (w_busy_live[0]),
        .i_end        (r_slot_end[0]),
        .i_weight     (r_slot_weight[0]),
        .i_new_weight (r_weight),
        .o_pick       (w_pick_int)
    );

    lsra_pick #(
        .NUM_REGS (NUM_FLOAT_REGS),
        .POS_W    (PW)
    ) u_pick_float (
        .i_busy       (w_busy_live[1]),
        .i_end        (r_slot_end[1]),
        .i_weight     (r_slot_weight[1]),
        .i_new_weight (r_weight),
        .o_pick       (w_pick_float)
    );

    assign w_pick        = r_float ? w_pick_float : w_pick_int;
    assign w_write       = w_pick.found_free || w_pick.found_victim;
    assign w_slot        = w_pick.found_free ? w_pick.free_idx : w_pick.victim_idx;
    assign w_victim_vreg = r_slot_vreg[r_float][w_pick.victim_idx];

    always_comb begin
        w_res0    = '0;
        w_res1    = '0;
        w_push2   = 1'b0;
        w_res0.cls = r_float;
        w_res1.cls = r_float;
        if (w_pick.found_free) begin
            w_res0.vreg      = r_vreg;
            w_res0.reg_index = w_pick.free_idx;
            w_res0.last      = 1'b1;
        end else if (w_pick.found_victim) begin
            w_res0.vreg      = w_victim_vreg;
            w_res0.spilled   = 1'b1;
            w_res0.evicted   = 1'b1;
            w_res1.vreg      = r_vreg;
            w_res1.reg_index = w_pick.victim_idx;
            w_res1.last      = 1'b1;
            w_push2          = 1'b1;
        end else begin
            w_res0.vreg    = r_vreg;
            w_res0.spilled = 1'b1;
            w_res0.last    = 1'b1;
        end
    end

    always_comb begin
        n_busy = w_busy_live;
        if (w_write) begin
            n_busy[r_float][w_slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (w_fire) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_write) begin
            r_slot_end[r_float][w_slot]    <= r_end;
            r_slot_weight[r_float][w_slot] <= r_weight;
            r_slot_vreg[r_float][w_slot]   <= r_vreg;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    assign w_push_n = w_fire ? (w_push2 ? 2'd2 : 2'd1) : 2'd0;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(w_push_n);
        n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
        n_count  = r_count + CNT_W'(w_push_n) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_fifo[r_wr_ptr] <= w_res0;
            if (w_push2) begin
                r_fifo[r_wr_ptr + PTR_W'(1)] <= w_res1;
            end
        end
    end

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {OUT_PAD_W'(0), w_head.reg_index, w_head.vreg};
    assign m_axis_tuser  = {w_head.evicted, w_head.spilled, w_head.cls};
    assign m_axis_tlast  = w_head.last;

endmodule

`default_nettype wire

// ===== rtl/lsra_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "linear_scan_register_assigner_defines.svh"

module lsra_checker
    import lsra_pkg::*;
#(
    parameter int NUM_INT_REGS   = NUM_INT_REGS_DEF,
    parameter int NUM_FLOAT_REGS = NUM_FLOAT_REGS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // stalled transaction holds
    `LSRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed while stalled")

    // an evicted holder is reported as spilled and is never the final result
    `LSRA_ASSERT_NOW(a_evict_first, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1] && !m_axis_tlast, "eviction report malformed")

    `LSRA_ASSERT_NOW(a_spill_idx, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[19:16] == 4'd0, "spilled result carries a register index")

    // the new interval follows the eviction report at once, same class, in a register
    `LSRA_ASSERT_NEXT(a_evict_pair, m_axis_tvalid && m_axis_tready && m_axis_tuser[2], m_axis_tvalid && m_axis_tlast && !m_axis_tuser[1] && !m_axis_tuser[2] && (m_axis_tuser[0] == $past(m_axis_tuser[0])), "eviction not followed by its assignment")

    `LSRA_ASSERT_NOW(a_idx_range, m_axis_tvalid && !m_axis_tuser[1], m_axis_tuser[0] ? (5'(m_axis_tdata[19:16]) < 5'(NUM_FLOAT_REGS)) : (5'(m_axis_tdata[19:16]) < 5'(NUM_INT_REGS)), "register index beyond class size")

endmodule

bind linear_scan_register_assigner lsra_checker #(
    .NUM_INT_REGS   (NUM_INT_REGS),
    .NUM_FLOAT_REGS (NUM_FLOAT_REGS)
) u_lsra_checker (.*);

`default_nettype wire

// ===== test/linear_scan_register_assigner_tb.sv =====
`timescale 1ns / 1ps

module linear_scan_register_assigner_tb;
    import lsra_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int IDLE_PERCENT   = 35;
    localparam int NUM_SLOTS      = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam logic CLASS_INT    = 1'b0;
    localparam logic CLASS_FLOAT  = 1'b1;

    typedef struct packed {
        logic [VREG_W-1:0]      vreg;
        logic [FIELD_POS_W-1:0] start_pos;
        logic [FIELD_POS_W-1:0] end_pos;
        logic                   fp_class;
        logic [WEIGHT_W-1:0]    weight;
    } t_interval;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    t_interval pending_intervals[$];
    t_interval cur_interval;
    t_result   awaited_results[$];
    int        intervals_total = 0;
    int        intervals_taken = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // predicted register file, SLOTS_PER_CLASS slots for each class
    logic                   held_busy[NUM_SLOTS];
    logic [FIELD_POS_W-1:0] held_end[NUM_SLOTS];
    logic [WEIGHT_W-1:0]    held_weight[NUM_SLOTS];
    logic [VREG_W-1:0]      held_vreg[NUM_SLOTS];

    linear_scan_register_assigner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result make_result(logic [VREG_W-1:0] vreg, int idx, logic cls,
                                            logic spilled, logic evicted, logic last);
        t_result r;
        r.vreg      = vreg;
        r.reg_index = idx[IDX_W-1:0];
        r.cls       = cls;
        r.spilled   = spilled;
        r.evicted   = evicted;
        r.last      = last;
        return r;
    endfunction

    // expiry, then free register, then cheapest strictly lighter holder, else self spill
    function automatic void assign_interval(t_interval iv);
        int base;
        int class_regs;
        int victim;
        int s;
        base       = iv.fp_class ? SLOTS_PER_CLASS : 0;
        class_regs = iv.fp_class ? NUM_FLOAT_REGS_DEF : NUM_INT_REGS_DEF;
        victim     = -1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (held_busy[k] && held_end[k] <= iv.start_pos) held_busy[k] = 1'b0;
        end
        for (int i = 0; i < class_regs; i++) begin
            s = base + i;
            if (!held_busy[s]) begin
                held_busy[s]   = 1'b1;
                held_end[s]    = iv.end_pos;
                held_weight[s] = iv.weight;
                held_vreg[s]   = iv.vreg;
                awaited_results = {awaited_results,
                                   make_result(iv.vreg, i, iv.fp_class, 1'b0, 1'b0, 1'b1)};
                return;
            end
        end
        for (int i = 0; i < class_regs; i++) begin
            s = base + i;
            if (held_weight[s] < iv.weight) begin
                if (victim < 0 || held_weight[s] < held_weight[victim] ||
                    (held_weight[s] == held_weight[victim] && held_end[s] < held_end[victim]))
                    victim = s;
            end
        end
        if (victim < 0) begin
            awaited_results = {awaited_results,
                               make_result(iv.vreg, 0, iv.fp_class, 1'b1, 1'b0, 1'b1)};
            return;
        end
        awaited_results = {awaited_results,
                           make_result(held_vreg[victim], 0, iv.fp_class, 1'b1, 1'b1, 1'b0)};
        held_end[victim]    = iv.end_pos;
        held_weight[victim] = iv.weight;
        held_vreg[victim]   = iv.vreg;
        awaited_results = {awaited_results,
                           make_result(iv.vreg, victim - base, iv.fp_class, 1'b0, 1'b0, 1'b1)};
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic queue_interval(logic [15:0] vreg, logic [15:0] start_pos,
                                  logic [15:0] end_pos, logic fp_class, logic [15:0] weight);
        t_interval iv;
        iv.vreg      = vreg;
        iv.start_pos = start_pos;
        iv.end_pos   = end_pos;
        iv.fp_class  = fp_class;
        iv.weight    = weight;
        pending_intervals = {pending_intervals, iv};
        intervals_total++;
    endtask

    // no idling on either side for a stretch in the middle of the run
    function automatic logic calm();
        return intervals_taken >= 300 && intervals_taken < 450;
    endfunction

    // driver: holds an interval until accepted, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                assign_interval(cur_interval);
                intervals_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_intervals.size() != 0 &&
                    (calm() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    cur_interval = pending_intervals.pop_front();
                    s_axis_tdata  <= {cur_interval.weight, cur_interval.end_pos,
                                      cur_interval.start_pos, cur_interval.vreg};
                    s_axis_tuser  <= cur_interval.fp_class;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, each result transaction checked in order
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result vreg %h", m_axis_tdata[15:0]));
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (m_axis_tdata[15:0] !== exp_r.vreg)
                        flag_mismatch($sformatf("vreg %h, want %h",
                                                m_axis_tdata[15:0], exp_r.vreg));
                    if (m_axis_tdata[19:16] !== exp_r.reg_index)
                        flag_mismatch($sformatf("reg_index %0d, want %0d (vreg %h)",
                                                m_axis_tdata[19:16], exp_r.reg_index,
                                                exp_r.vreg));
                    if (m_axis_tdata[23:20] !== '0)
                        flag_mismatch($sformatf("pad bits %h", m_axis_tdata[23:20]));
                    if (m_axis_tuser[0] !== exp_r.cls)
                        flag_mismatch($sformatf("class %b, want %b (vreg %h)",
                                                m_axis_tuser[0], exp_r.cls, exp_r.vreg));
                    if (m_axis_tuser[1] !== exp_r.spilled)
                        flag_mismatch($sformatf("spilled %b, want %b (vreg %h)",
                                                m_axis_tuser[1], exp_r.spilled, exp_r.vreg));
                    if (m_axis_tuser[2] !== exp_r.evicted)
                        flag_mismatch($sformatf("evicted %b, want %b (vreg %h)",
                                                m_axis_tuser[2], exp_r.evicted, exp_r.vreg));
                    if (m_axis_tlast !== exp_r.last)
                        flag_mismatch($sformatf("tlast %b, want %b (vreg %h)",
                                                m_axis_tlast, exp_r.last, exp_r.vreg));
                end
            end
            m_axis_tready <= calm() || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("linear_scan_register_assigner_tb failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] pos;
        logic [15:0] len;
        int          seg_left;
        int          max_len;
        int          pick;
        logic [15:0] wt;
        logic [15:0] end_p;

        for (int k = 0; k < NUM_SLOTS; k++) begin
            held_busy[k]   = 1'b0;
            held_end[k]    = '0;
            held_weight[k] = '0;
            held_vreg[k]   = '0;
        end

        // empty interval with zero weight, then field extremes, then an empty float interval
        queue_interval(16'h0000, 16'h0000, 16'h0000, CLASS_INT, 16'h0000);
        queue_interval(16'hFFFF, 16'h0000, 16'hFFFF, CLASS_INT, 16'hFFFF);
        queue_interval(16'h1234, 16'h0001, 16'h0001, CLASS_FLOAT, 16'h0005);
        // fill every float register; weights 3..6 with ties broken on end
        for (int i = 0; i < SLOTS_PER_CLASS; i++)
            queue_interval(16'h0100 + 16'(i), 16'h0002, 16'd300 + 16'(i % 5), CLASS_FLOAT,
                           16'(3 + i % 4));
        // zero weight and equal weight cannot evict
        queue_interval(16'h0200, 16'h0003, 16'd400, CLASS_FLOAT, 16'h0000);
        queue_interval(16'h0201, 16'h0003, 16'd400, CLASS_FLOAT, 16'h0003);
        // heaviest weight evicts lightest, earliest-ending holder
        queue_interval(16'h0202, 16'h0003, 16'd400, CLASS_FLOAT, 16'hFFFF);
        // start going backwards
        queue_interval(16'h0203, 16'h0001, 16'h0002, CLASS_INT, 16'h0007);
        // top start frees everything; end wraps below start
        queue_interval(16'hABCD, 16'hFFFF, 16'h0000, CLASS_FLOAT, 16'h8000);

        // segments of ordered intervals from random bases with varied lifetimes
        pos = 16'($urandom);
        seg_left = 0;
        max_len = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = int'($urandom_range(40, 120));
                pos = 16'($urandom);
                pick = int'($urandom_range(0, 2));
                max_len = (pick == 0) ? 20 : (pick == 1) ? 60 : 150;
            end
            seg_left--;
            pos = pos + 16'($urandom_range(0, 3));
            pick = int'($urandom_range(0, 99));
            if (pick < 85) begin
                len = 16'($urandom_range(1, max_len));
                end_p = pos + len;
            end else if (pick < 90) begin
                end_p = pos - 16'($urandom_range(0, 3));
            end else begin
                end_p = 16'($urandom);
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 70) wt = 16'($urandom_range(0, 7));
            else if (pick < 90) wt = 16'($urandom);
            else wt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            queue_interval(16'($urandom), pos, end_p, 1'($urandom_range(0, 1)), wt);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (intervals_taken < intervals_total || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("linear_scan_register_assigner_tb passed");
        end else begin
            $display("linear_scan_register_assigner_tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lsra_pkg.sv
rtl/lsra_pick.sv
rtl/linear_scan_register_assigner.sv
rtl/lsra_checker.sv
test/linear_scan_register_assigner_tb.sv
